// ----- hdl/cmc_pkg.sv -----
`timescale 1ns / 1ps

package cmc_pkg;

	typedef enum logic [1:0] {
		MODE_OFF = 2'd0,
		MODE_OVR = 2'd1,
		MODE_ACT = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		BTN_NONE   = 2'd0,
		BTN_SET    = 2'd1,
		BTN_RESUME = 2'd2,
		BTN_CANCEL = 2'd3
	} btn_t;

	typedef enum logic [2:0] {
		REG_MIN_VEH_SPEED  = 3'd0,
		REG_MAX_VEH_SPEED  = 3'd1,
		REG_MIN_SET_SPEED  = 3'd2,
		REG_MAX_SET_SPEED  = 3'd3,
		REG_MAX_RESUME_GAP = 3'd4,
		REG_RPM_STALE      = 3'd5,
		REG_PEDAL_ENGAGE   = 3'd6,
		REG_PEDAL_RELEASE  = 3'd7
	} reg_idx_t;

	localparam logic [13:0] RPM_LOW  = 14'd600;
	localparam logic [13:0] RPM_HIGH = 14'd7000;
	localparam logic signed [13:0] STEP_UNITS = 14'sd16;

	localparam logic [11:0] RST_MIN_VEH_SPEED  = 12'd480;
	localparam logic [11:0] RST_MAX_VEH_SPEED  = 12'd2400;
	localparam logic [11:0] RST_MIN_SET_SPEED  = 12'd480;
	localparam logic [11:0] RST_MAX_SET_SPEED  = 12'd2400;
	localparam logic [11:0] RST_MAX_RESUME_GAP = 12'd160;
	localparam logic [15:0] RST_RPM_STALE      = 16'd500;
	localparam logic [9:0]  RST_PEDAL_ENGAGE   = 10'd102;
	localparam logic [9:0]  RST_PEDAL_RELEASE  = 10'd51;

	typedef struct packed {
		logic [11:0] speed;
		logic        speed_valid;
		logic [13:0] rpm;
		logic [15:0] rpm_age_ms;
		logic        brake_pressed;
		logic        clutch_pressed;
		logic [9:0]  pedal_level;
		logic [1:0]  button;
	} tick_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  indicator_mode;
		logic [11:0] target_speed;
		logic        override_enable;
		logic        throttle_zero;
		logic        pid_reset;
		logic        pid_run;
		logic        button_event;
	} result_t;

	typedef struct packed {
		logic [11:0] min_vehicle_speed;
		logic [11:0] max_vehicle_speed;
		logic [11:0] min_set_speed;
		logic [11:0] max_set_speed;
		logic [11:0] max_resume_gap;
		logic [15:0] rpm_stale_limit_ms;
		logic [9:0]  pedal_engage_level;
		logic [9:0]  pedal_release_level;
	} cfg_t;

endpackage

// ----- hdl/cmc_cfg_regs.sv -----
`timescale 1ns / 1ps

module cmc_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	output cmc_pkg::cfg_t  cfg
);

	cmc_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_vehicle_speed   <= cmc_pkg::RST_MIN_VEH_SPEED;
			cfg_q.max_vehicle_speed   <= cmc_pkg::RST_MAX_VEH_SPEED;
			cfg_q.min_set_speed       <= cmc_pkg::RST_MIN_SET_SPEED;
			cfg_q.max_set_speed       <= cmc_pkg::RST_MAX_SET_SPEED;
			cfg_q.max_resume_gap      <= cmc_pkg::RST_MAX_RESUME_GAP;
			cfg_q.rpm_stale_limit_ms  <= cmc_pkg::RST_RPM_STALE;
			cfg_q.pedal_engage_level  <= cmc_pkg::RST_PEDAL_ENGAGE;
			cfg_q.pedal_release_level <= cmc_pkg::RST_PEDAL_RELEASE;
		end else if (wr_en) begin
			unique case (idx)
				cmc_pkg::REG_MIN_VEH_SPEED:  cfg_q.min_vehicle_speed   <= pwdata[11:0];
				cmc_pkg::REG_MAX_VEH_SPEED:  cfg_q.max_vehicle_speed   <= pwdata[11:0];
				cmc_pkg::REG_MIN_SET_SPEED:  cfg_q.min_set_speed       <= pwdata[11:0];
				cmc_pkg::REG_MAX_SET_SPEED:  cfg_q.max_set_speed       <= pwdata[11:0];
				cmc_pkg::REG_MAX_RESUME_GAP: cfg_q.max_resume_gap      <= pwdata[11:0];
				cmc_pkg::REG_RPM_STALE:      cfg_q.rpm_stale_limit_ms  <= pwdata[15:0];
				cmc_pkg::REG_PEDAL_ENGAGE:   cfg_q.pedal_engage_level  <= pwdata[9:0];
				cmc_pkg::REG_PEDAL_RELEASE:  cfg_q.pedal_release_level <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			cmc_pkg::REG_MIN_VEH_SPEED:  prdata = {20'd0, cfg_q.min_vehicle_speed};
			cmc_pkg::REG_MAX_VEH_SPEED:  prdata = {20'd0, cfg_q.max_vehicle_speed};
			cmc_pkg::REG_MIN_SET_SPEED:  prdata = {20'd0, cfg_q.min_set_speed};
			cmc_pkg::REG_MAX_SET_SPEED:  prdata = {20'd0, cfg_q.max_set_speed};
			cmc_pkg::REG_MAX_RESUME_GAP: prdata = {20'd0, cfg_q.max_resume_gap};
			cmc_pkg::REG_RPM_STALE:      prdata = {16'd0, cfg_q.rpm_stale_limit_ms};
			cmc_pkg::REG_PEDAL_ENGAGE:   prdata = {22'd0, cfg_q.pedal_engage_level};
			cmc_pkg::REG_PEDAL_RELEASE:  prdata = {22'd0, cfg_q.pedal_release_level};
			default:                     prdata = 32'd0;
		endcase
	end

endmodule

// ----- hdl/cmc_btn.sv -----
`timescale 1ns / 1ps

module cmc_btn #(
	parameter int unsigned REPEAT_DELAY  = 10,
	parameter int unsigned REPEAT_PERIOD = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [1:0] button,
	output logic       ev
);

	localparam int unsigned LIMIT = REPEAT_DELAY + REPEAT_PERIOD;
	localparam int unsigned HW    = $clog2(LIMIT);

	logic [1:0]    last_q;
	logic [HW-1:0] hold_q;
	logic [HW-1:0] hold_d;
	logic [HW:0]   hold_inc;

	always_comb begin
		hold_inc = {1'b0, hold_q} + (HW+1)'(1);
		hold_d   = hold_q;
		ev       = 1'b0;
		if (button != last_q) begin
			// press clears the repeat timer; release is no event
			if (button != cmc_pkg::BTN_NONE) begin
				hold_d = '0;
				ev     = 1'b1;
			end
		end else if (button != cmc_pkg::BTN_NONE) begin
			// fold back to the delay point so repeats keep the period
			if (hold_inc >= (HW+1)'(LIMIT)) begin
				hold_d = HW'(REPEAT_DELAY);
			end else begin
				hold_d = hold_inc[HW-1:0];
			end
			ev = ({1'b0, hold_d} == (HW+1)'(REPEAT_DELAY));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= cmc_pkg::BTN_NONE;
			hold_q <= '0;
		end else if (en) begin
			last_q <= button;
			hold_q <= hold_d;
		end
	end

endmodule

// ----- hdl/cmc_mode_fsm.sv -----
`timescale 1ns / 1ps

module cmc_mode_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  cmc_pkg::tick_t   tick,
	input  cmc_pkg::cfg_t    cfg,
	input  logic             ev,
	output cmc_pkg::result_t res
);

	cmc_pkg::mode_t   mode_q;
	cmc_pkg::mode_t   mode_d;
	logic [11:0]      target_q;
	logic [11:0]      target_d;
	logic             elig_base;
	logic             resume_ok;
	logic [11:0]      gap;
	logic             strobe;
	logic             run;
	logic signed [13:0] t_step;
	logic signed [13:0] t_min;
	logic signed [13:0] t_max;

	always_comb begin
		elig_base = !tick.brake_pressed && !tick.clutch_pressed && tick.speed_valid
			&& (tick.speed >= cfg.min_vehicle_speed) && (tick.speed <= cfg.max_vehicle_speed)
			&& (tick.rpm_age_ms <= cfg.rpm_stale_limit_ms)
			&& (tick.rpm >= cmc_pkg::RPM_LOW) && (tick.rpm <= cmc_pkg::RPM_HIGH);
		gap = (tick.speed > target_q) ? (tick.speed - target_q) : (target_q - tick.speed);
		resume_ok = (target_q >= cfg.min_set_speed) && (target_q <= cfg.max_set_speed)
			&& (gap <= cfg.max_resume_gap);

		t_min  = $signed({2'b00, cfg.min_set_speed});
		t_max  = $signed({2'b00, cfg.max_set_speed});
		t_step = $signed({2'b00, target_q});
		if (tick.button == cmc_pkg::BTN_SET) begin
			t_step = t_step - cmc_pkg::STEP_UNITS;
		end else if (tick.button == cmc_pkg::BTN_RESUME) begin
			t_step = t_step + cmc_pkg::STEP_UNITS;
		end
		// when the bounds cross, the lower bound wins only for a step below it, else the upper bound
		if (t_step < t_min) begin
			t_step = t_min;
		end else if (t_step > t_max) begin
			t_step = t_max;
		end
	end

	always_comb begin
		mode_d   = mode_q;
		target_d = target_q;
		strobe   = 1'b0;
		run      = 1'b0;
		unique case (mode_q)
			cmc_pkg::MODE_OVR: begin
				if (!elig_base || tick.button == cmc_pkg::BTN_CANCEL) begin
					mode_d = cmc_pkg::MODE_OFF;
					strobe = 1'b1;
				end else if (tick.pedal_level < cfg.pedal_release_level) begin
					mode_d = cmc_pkg::MODE_ACT;
					strobe = 1'b1;
				end
			end
			cmc_pkg::MODE_ACT: begin
				if (!elig_base || tick.button == cmc_pkg::BTN_CANCEL) begin
					mode_d = cmc_pkg::MODE_OFF;
					strobe = 1'b1;
				end else if (tick.pedal_level > cfg.pedal_engage_level) begin
					mode_d = cmc_pkg::MODE_OVR;
					strobe = 1'b1;
				end else begin
					if (ev) begin
						target_d = t_step[11:0];
					end
					run = 1'b1;
				end
			end
			default: begin
				mode_d = cmc_pkg::MODE_OFF;
				if (ev && (tick.button == cmc_pkg::BTN_SET
						|| tick.button == cmc_pkg::BTN_RESUME)) begin
					if (elig_base && (tick.button == cmc_pkg::BTN_SET || resume_ok)) begin
						if (tick.button == cmc_pkg::BTN_SET) begin
							target_d = tick.speed;
						end
						strobe = 1'b1;
						mode_d = (tick.pedal_level > cfg.pedal_engage_level)
							? cmc_pkg::MODE_OVR : cmc_pkg::MODE_ACT;
					end
				end
			end
		endcase

		res.mode            = mode_d;
		res.indicator_mode  = mode_q;
		res.target_speed    = target_d;
		res.override_enable = (mode_d == cmc_pkg::MODE_ACT);
		res.throttle_zero   = strobe;
		res.pid_reset       = strobe;
		res.pid_run         = run;
		res.button_event    = ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= cmc_pkg::MODE_OFF;
			target_q <= '0;
		end else if (en) begin
			mode_q   <= mode_d;
			target_q <= target_d;
		end
	end

endmodule

// ----- hdl/cruise_mode_controller_top.sv -----
// Cruise mode controller: one control tick per item, one result item per tick.
// An item is taken every cycle unless tick_stall is raised; it passes through the input
// register, then the mode, eligibility and target logic into the result register, from
// which its result is offered. Mode, target and button repeat state advance only when an
// item moves into the result register, so stalls on the result side hold that state.
// Speeds are in 1/16 km/h; a held set or resume button repeats after
// REPEAT_DELAY ticks and then every REPEAT_PERIOD ticks, stepping the target
// by 1 km/h in active mode. Registers sit on the APB port at byte address 4*i.
`timescale 1ns / 1ps

module cruise_mode_controller_top #(
	parameter int unsigned REPEAT_DELAY  = 10,
	parameter int unsigned REPEAT_PERIOD = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick_valid,
	output logic             tick_stall,
	input  cmc_pkg::tick_t   tick,
	output logic             result_valid,
	input  logic             result_stall,
	output cmc_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cmc_pkg::cfg_t    cfg;
	cmc_pkg::tick_t   tick_s1;
	logic             tick_valid_s1;
	cmc_pkg::result_t res_d;
	cmc_pkg::result_t result_s2;
	logic             result_valid_s2;
	logic             advance;
	logic             ev;

	assign advance      = tick_valid_s1 && (!result_valid_s2 || !result_stall);
	assign tick_stall   = tick_valid_s1 && !advance;
	assign result_valid = result_valid_s2;
	assign result       = result_s2;

	cmc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cmc_btn #(
		.REPEAT_DELAY  (REPEAT_DELAY),
		.REPEAT_PERIOD (REPEAT_PERIOD)
	) u_btn (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.button (tick_s1.button),
		.ev     (ev)
	);

	cmc_mode_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.tick   (tick_s1),
		.cfg    (cfg),
		.ev     (ev),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			tick_valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s1 <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res_d;
		end
	end

`ifndef SYNTHESIS
	// a mode change always strobes the regulator reset and throttle zero
	a_strobe_on_change: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_s2 |-> (result_s2.pid_reset == (result_s2.mode != result_s2.indicator_mode))
			&& (result_s2.throttle_zero == result_s2.pid_reset))
		else $error("strobe does not match mode change");

	a_run_active: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_s2 && result_s2.pid_run) |->
			(result_s2.mode == cmc_pkg::MODE_ACT && result_s2.indicator_mode == cmc_pkg::MODE_ACT))
		else $error("regulator run outside steady active mode");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid_s2)
		else $error("result register lost an item");

	a_chain_mode: assert property (@(posedge clk) disable iff (!arst_n)
		advance ##1 (tick_valid_s1 && advance) |->
			(res_d.indicator_mode == result_s2.mode))
		else $error("mode state does not follow previous result");
`endif

endmodule
